### hw/rtl/pav_pkg.sv
// Shared types, widths, register codes and helpers for the particle advection block.
// No dependencies; every file but pav_stream_if imports this package.
package pav_pkg;

    localparam int GRID_CELLS_DEF    = 64;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int POS_W       = 23;
    localparam int VEL_W       = 24;
    localparam int DT_W        = 16;
    localparam int NORM_BITS   = 28;
    localparam int PROD_W      = VEL_W + DT_W + 1;
    localparam int AP_W        = POS_W + 4;
    localparam int MAG_W       = 34;
    localparam int DX_W        = MAG_W + 1;
    localparam int SCALE_LIMIT = 30;
    localparam int MAX_SHIFT   = MAG_W - SCALE_LIMIT;
    localparam int SH_W        = 3;
    localparam int SC_W        = SCALE_LIMIT + 1;
    localparam int SQ_W        = 2 * SCALE_LIMIT + 2;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int SR_W        = ROOT_W + 3;
    localparam int REM_W       = ROOT_W + 1;
    localparam int NQ_W        = NORM_BITS + 1;
    localparam int N_W         = NORM_BITS + 2;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = 8'd1;
    localparam logic [DT_W-1:0]      TIME_STEP_RST     = 16'd3277;

    typedef enum logic {
        MODE_BOX    = 1'b0,
        MODE_CIRCLE = 1'b1
    } pav_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } pav_in_t;

    typedef struct packed {
        logic [POS_W-1:0]        new_pos_x;
        logic [POS_W-1:0]        new_pos_y;
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
    } pav_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } pav_cfg_t;

    typedef struct packed {
        logic signed [AP_W-1:0]  px;
        logic signed [AP_W-1:0]  py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        pav_mode_t               mode;
        logic                    hit;
        logic signed [SC_W-1:0]  dxs;
        logic signed [SC_W-1:0]  dys;
    } pav_item_t;

    function automatic logic [MAG_W-1:0] center_of(input int grid_cells,
                                                   input int fraction_bits);
        return MAG_W'(grid_cells) << (fraction_bits - 1);
    endfunction

    function automatic logic signed [PROD_W-1:0] round_dt(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] bias;
        bias = PROD_W'(1) <<< (DT_W - 1);
        return (p + bias) >>> DT_W;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< POS_W) - 64'sd1;
        if (v < 0)
            return '0;
        else if (v > hi)
            return '1;
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (VEL_W - 1));
        if (v < lo)
            return lo[VEL_W-1:0];
        else if (v > hi)
            return hi[VEL_W-1:0];
        else
            return v[VEL_W-1:0];
    endfunction

endpackage

### hw/rtl/pav_stream_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is a parameter; used with types from pav_pkg.
interface pav_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/particle_advect_with_wall_bounce.sv
// Particle advection with wall bounce: fully pipelined, one particle per clock when the
// output does not stall. Accepts one beat per cycle then; each result passes through the
// 6 front stages, 31 square-root stages, 29 divider stages and 4 back stages incl. the
// output register. The pipeline advances as a whole; it freezes only while the
// output register holds a beat that has not been taken. Write configuration while idle.
module particle_advect_with_wall_bounce #(
    parameter int GRID_CELLS    = pav_pkg::GRID_CELLS_DEF,
    parameter int FRACTION_BITS = pav_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pav_stream_if.sink   particle,
    pav_stream_if.source result,
    pav_stream_if.sink   cfg
);
    import pav_pkg::*;

    logic [DT_W-1:0]        time_step_reg;
    pav_mode_t              mode_reg;
    logic                   en;
    logic                   fr_valid, sq_valid, dv_valid, rf_valid;
    pav_item_t              fr_item, sq_item, dv_item;
    logic [SQ_W-1:0]        fr_d2;
    logic [ROOT_W-1:0]      sq_dist;
    logic signed [N_W-1:0]  dv_nx, dv_ny;
    pav_out_t               rf_data;

    assign en             = result.ready || !rf_valid;
    assign particle.ready = en;
    assign cfg.ready      = 1'b1;
    assign result.valid   = rf_valid;
    assign result.data    = rf_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RST;
            mode_reg      <= MODE_CIRCLE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.data.index)
                REG_TIME_STEP:     time_step_reg <= cfg.data.value[DT_W-1:0];
                REG_BOUNDARY_MODE: mode_reg      <= pav_mode_t'(cfg.data.value[0]);
                default:           time_step_reg <= time_step_reg;
            endcase
        end
    end

    pav_front #(
        .GRID_CELLS    (GRID_CELLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (particle.valid),
        .in_data   (particle.data),
        .time_step (time_step_reg),
        .mode      (mode_reg),
        .out_valid (fr_valid),
        .out_item  (fr_item),
        .out_d2    (fr_d2)
    );

    pav_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .in_d2     (fr_d2),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_dist  (sq_dist)
    );

    pav_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .in_dist   (sq_dist),
        .out_valid (dv_valid),
        .out_item  (dv_item),
        .out_nx    (dv_nx),
        .out_ny    (dv_ny)
    );

    pav_reflect #(
        .GRID_CELLS    (GRID_CELLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_reflect (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .in_nx     (dv_nx),
        .in_ny     (dv_ny),
        .out_valid (rf_valid),
        .out_data  (rf_data)
    );

`ifndef NO_ASSERTIONS
    a_cfg_step: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.data.index == REG_TIME_STEP |=>
            time_step_reg == $past(cfg.data.value))
        else $error("time step write lost");

    a_cfg_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.data.index == REG_BOUNDARY_MODE |=>
            mode_reg == pav_mode_t'($past(cfg.data.value[0])))
        else $error("boundary mode write lost");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !particle.ready)
        else $error("beat accepted while output stalled");
`endif

endmodule

### hw/rtl/pav_front.sv
// Front stages: advance by velocity times step, center offset, common scaling, wall test.
// Depends on pav_pkg.
module pav_front #(
    parameter int GRID_CELLS    = pav_pkg::GRID_CELLS_DEF,
    parameter int FRACTION_BITS = pav_pkg::FRACTION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  pav_pkg::pav_in_t          in_data,
    input  logic [pav_pkg::DT_W-1:0]  time_step,
    input  pav_pkg::pav_mode_t        mode,
    output logic                      out_valid,
    output pav_pkg::pav_item_t        out_item,
    output logic [pav_pkg::SQ_W-1:0]  out_d2
);
    import pav_pkg::*;

    localparam logic [MAG_W-1:0]       CENTER_MAG = center_of(GRID_CELLS, FRACTION_BITS);
    localparam logic signed [DX_W-1:0] CENTER_S   = DX_W'(CENTER_MAG);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    pav_item_t                 it1_next, it1_reg, it2_next, it2_reg, it3_reg, it4_next, it4_reg;
    pav_item_t                 it5_reg, it6_next, it6_reg;
    logic signed [PROD_W-1:0]  prodx1_next, prody1_next, prodx1_reg, prody1_reg;
    logic signed [DX_W-1:0]    dx3, dy3;
    logic [MAG_W-1:0]          magx3_next, magy3_next, magx3_reg, magy3_reg;
    logic                      negx3_reg, negy3_reg;
    logic [MAG_W-1:0]          m4;
    logic [SH_W-1:0]           sh4;
    logic [SCALE_LIMIT-1:0]    ax4_next, ay4_next, cs4_next, ax4_reg, ay4_reg, cs4_reg;
    logic [2*SCALE_LIMIT-1:0]  sqx5_reg, sqy5_reg, sqc5_reg;
    logic [SQ_W-1:0]           d2_6_next, d2_6_reg;

    always_comb
    begin
        it1_next      = '0;
        it1_next.px   = AP_W'({1'b0, in_data.pos_x});
        it1_next.py   = AP_W'({1'b0, in_data.pos_y});
        it1_next.vx   = in_data.vel_x;
        it1_next.vy   = in_data.vel_y;
        it1_next.mode = mode;
        prodx1_next   = in_data.vel_x * $signed({1'b0, time_step});
        prody1_next   = in_data.vel_y * $signed({1'b0, time_step});
    end

    always_comb
    begin
        it2_next    = it1_reg;
        it2_next.px = it1_reg.px + AP_W'(round_dt(prodx1_reg));
        it2_next.py = it1_reg.py + AP_W'(round_dt(prody1_reg));
    end

    always_comb
    begin
        dx3        = DX_W'(it2_reg.px) - CENTER_S;
        dy3        = DX_W'(it2_reg.py) - CENTER_S;
        magx3_next = MAG_W'(dx3[DX_W-1] ? -dx3 : dx3);
        magy3_next = MAG_W'(dy3[DX_W-1] ? -dy3 : dy3);
    end

    always_comb
    begin
        m4 = magx3_reg;
        if (magy3_reg > m4)
            m4 = magy3_reg;
        if (CENTER_MAG > m4)
            m4 = CENTER_MAG;
        sh4 = SH_W'(MAX_SHIFT);
        for (int k = MAX_SHIFT; k >= 0; k--)
        begin
            if ((m4 >> k) < (MAG_W'(1) << SCALE_LIMIT))
                sh4 = SH_W'(k);
        end
        ax4_next     = SCALE_LIMIT'(magx3_reg >> sh4);
        ay4_next     = SCALE_LIMIT'(magy3_reg >> sh4);
        cs4_next     = SCALE_LIMIT'(CENTER_MAG >> sh4);
        it4_next     = it3_reg;
        it4_next.dxs = negx3_reg ? -$signed(SC_W'(ax4_next)) : $signed(SC_W'(ax4_next));
        it4_next.dys = negy3_reg ? -$signed(SC_W'(ay4_next)) : $signed(SC_W'(ay4_next));
    end

    always_comb
    begin
        d2_6_next    = SQ_W'(sqx5_reg) + SQ_W'(sqy5_reg);
        it6_next     = it5_reg;
        it6_next.hit = d2_6_next > SQ_W'(sqc5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg    <= it1_next;
            prodx1_reg <= prodx1_next;
            prody1_reg <= prody1_next;
            it2_reg    <= it2_next;
            it3_reg    <= it2_reg;
            magx3_reg  <= magx3_next;
            magy3_reg  <= magy3_next;
            negx3_reg  <= dx3[DX_W-1];
            negy3_reg  <= dy3[DX_W-1];
            it4_reg    <= it4_next;
            ax4_reg    <= ax4_next;
            ay4_reg    <= ay4_next;
            cs4_reg    <= cs4_next;
            it5_reg    <= it4_reg;
            sqx5_reg   <= ax4_reg * ax4_reg;
            sqy5_reg   <= ay4_reg * ay4_reg;
            sqc5_reg   <= cs4_reg * cs4_reg;
            it6_reg    <= it6_next;
            d2_6_reg   <= d2_6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_item  = it6_reg;
    assign out_d2    = d2_6_reg;

endmodule

### hw/rtl/pav_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on pav_pkg.
module pav_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  pav_pkg::pav_item_t          in_item,
    input  logic [pav_pkg::SQ_W-1:0]    in_d2,
    output logic                        out_valid,
    output pav_pkg::pav_item_t          out_item,
    output logic [pav_pkg::ROOT_W-1:0]  out_dist
);
    import pav_pkg::*;

    logic              vld_reg  [ROOT_W];
    pav_item_t         item_reg [ROOT_W];
    logic [SQ_W-1:0]   rad_reg  [ROOT_W];
    logic [SR_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              vld_src;
        pav_item_t         item_src;
        logic [SQ_W-1:0]   rad_src;
        logic [SR_W-1:0]   rem_src, cur, trial, rem_next;
        logic [ROOT_W-1:0] root_src, root_next;

        if (k == 0)
        begin : g_head
            assign vld_src  = in_valid;
            assign item_src = in_item;
            assign rad_src  = in_d2;
            assign rem_src  = '0;
            assign root_src = '0;
        end
        else
        begin : g_body
            assign vld_src  = vld_reg[k-1];
            assign item_src = item_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_src[SR_W-3:0], rad_src[SQ_W-1 -: 2]};
            trial = SR_W'({root_src, 2'b01});
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_src[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_src[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_src;
                rad_reg[k]  <= rad_src << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_item  = item_reg[ROOT_W-1];
    assign out_dist  = root_reg[ROOT_W-1];

endmodule

### hw/rtl/pav_div.sv
// Pipelined restoring dividers for the Q.28 wall normal, x and y side by side.
// Depends on pav_pkg.
module pav_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  pav_pkg::pav_item_t               in_item,
    input  logic [pav_pkg::ROOT_W-1:0]       in_dist,
    output logic                             out_valid,
    output pav_pkg::pav_item_t               out_item,
    output logic signed [pav_pkg::N_W-1:0]   out_nx,
    output logic signed [pav_pkg::N_W-1:0]   out_ny
);
    import pav_pkg::*;

    logic              vld_reg  [NQ_W];
    pav_item_t         item_reg [NQ_W];
    logic [ROOT_W-1:0] dist_reg [NQ_W];
    logic [REM_W-1:0]  remx_reg [NQ_W];
    logic [REM_W-1:0]  remy_reg [NQ_W];
    logic [NQ_W-1:0]   qx_reg   [NQ_W];
    logic [NQ_W-1:0]   qy_reg   [NQ_W];

    logic signed [SC_W-1:0] absx_in, absy_in;

    assign absx_in = in_item.dxs[SC_W-1] ? -in_item.dxs : in_item.dxs;
    assign absy_in = in_item.dys[SC_W-1] ? -in_item.dys : in_item.dys;

    for (genvar k = 0; k < NQ_W; k++)
    begin : g_stage
        logic              vld_src;
        pav_item_t         item_src;
        logic [ROOT_W-1:0] dist_src;
        logic [REM_W-1:0]  remx_src, remy_src, rx, ry;
        logic [NQ_W-1:0]   qx_src, qy_src;
        logic              bx, by;

        if (k == 0)
        begin : g_head
            assign vld_src  = in_valid;
            assign item_src = in_item;
            assign dist_src = in_dist;
            assign remx_src = REM_W'(unsigned'(absx_in));
            assign remy_src = REM_W'(unsigned'(absy_in));
            assign qx_src   = '0;
            assign qy_src   = '0;
        end
        else
        begin : g_body
            assign vld_src  = vld_reg[k-1];
            assign item_src = item_reg[k-1];
            assign dist_src = dist_reg[k-1];
            assign remx_src = remx_reg[k-1];
            assign remy_src = remy_reg[k-1];
            assign qx_src   = qx_reg[k-1];
            assign qy_src   = qy_reg[k-1];
        end

        always_comb
        begin
            bx = remx_src >= REM_W'(dist_src);
            by = remy_src >= REM_W'(dist_src);
            rx = bx ? remx_src - REM_W'(dist_src) : remx_src;
            ry = by ? remy_src - REM_W'(dist_src) : remy_src;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_src;
                dist_reg[k] <= dist_src;
                remx_reg[k] <= rx << 1;
                remy_reg[k] <= ry << 1;
                qx_reg[k]   <= {qx_src[NQ_W-2:0], bx};
                qy_reg[k]   <= {qy_src[NQ_W-2:0], by};
            end
        end
    end

    assign out_valid = vld_reg[NQ_W-1];
    assign out_item  = item_reg[NQ_W-1];
    assign out_nx    = item_reg[NQ_W-1].dxs[SC_W-1] ? -$signed(N_W'(qx_reg[NQ_W-1]))
                                                    : $signed(N_W'(qx_reg[NQ_W-1]));
    assign out_ny    = item_reg[NQ_W-1].dys[SC_W-1] ? -$signed(N_W'(qy_reg[NQ_W-1]))
                                                    : $signed(N_W'(qy_reg[NQ_W-1]));

endmodule

### hw/rtl/pav_reflect.sv
// Back stages: wall projection, velocity mirror, box clamp, saturation and output register.
// Depends on pav_pkg.
module pav_reflect #(
    parameter int GRID_CELLS    = pav_pkg::GRID_CELLS_DEF,
    parameter int FRACTION_BITS = pav_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  pav_pkg::pav_item_t              in_item,
    input  logic signed [pav_pkg::N_W-1:0]  in_nx,
    input  logic signed [pav_pkg::N_W-1:0]  in_ny,
    output logic                            out_valid,
    output pav_pkg::pav_out_t               out_data
);
    import pav_pkg::*;

    localparam int PC_W   = N_W + DX_W;
    localparam int CP_W   = PC_W - NORM_BITS + 1;
    localparam int DOTS_W = VEL_W + N_W + 1;
    localparam int DOT_W  = DOTS_W - NORM_BITS;
    localparam int DN_W   = DOT_W + N_W;

    localparam logic [MAG_W-1:0]         CENTER_MAG = center_of(GRID_CELLS, FRACTION_BITS);
    localparam logic signed [DX_W-1:0]   CENTER_S   = DX_W'(CENTER_MAG);
    localparam logic signed [63:0]       SIZE64     = 64'(CENTER_MAG) << 1;
    localparam logic signed [63:0]       TENTH64    = 64'(((1 << FRACTION_BITS) + 5) / 10);
    localparam logic signed [PC_W-1:0]   PC_BIAS    = PC_W'(1) <<< (NORM_BITS - 1);
    localparam logic signed [DOTS_W-1:0] DOT_BIAS   = DOTS_W'(1) <<< (NORM_BITS - 1);
    localparam logic signed [DN_W-1:0]   DN_BIAS    = DN_W'(1) <<< (NORM_BITS - 2);

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    pav_item_t                     it1_reg, it2_reg, it3_reg, it4_reg;
    logic signed [N_W-1:0]         nx1_reg, ny1_reg, nx2_reg, ny2_reg;
    logic signed [PC_W-1:0]        pcx1_reg, pcy1_reg;
    logic signed [VEL_W+N_W-1:0]   dvx1_reg, dvy1_reg;
    logic signed [DOTS_W-1:0]      dsum2;
    logic signed [PC_W-1:0]        prx2, pry2;
    logic signed [CP_W-1:0]        posx2_next, posy2_next, posx2_reg, posy2_reg;
    logic signed [CP_W-1:0]        posx3_reg, posy3_reg;
    logic signed [DOT_W-1:0]       dot2_next, dot2_reg;
    logic signed [DN_W-1:0]        dnx3_reg, dny3_reg;
    logic signed [DN_W-1:0]        corrx4, corry4, velx4, vely4;
    logic signed [63:0]            fpx, fpy, fvx, fvy;
    pav_out_t                      res_next, res_reg;

    always_comb
    begin
        dsum2      = DOTS_W'(dvx1_reg) + DOTS_W'(dvy1_reg);
        dot2_next  = DOT_W'((dsum2 + DOT_BIAS) >>> NORM_BITS);
        prx2       = (pcx1_reg + PC_BIAS) >>> NORM_BITS;
        pry2       = (pcy1_reg + PC_BIAS) >>> NORM_BITS;
        posx2_next = CP_W'(CENTER_S) + CP_W'(prx2);
        posy2_next = CP_W'(CENTER_S) + CP_W'(pry2);
    end

    always_comb
    begin
        corrx4 = (dnx3_reg + DN_BIAS) >>> (NORM_BITS - 1);
        corry4 = (dny3_reg + DN_BIAS) >>> (NORM_BITS - 1);
        velx4  = DN_W'(it3_reg.vx) - corrx4;
        vely4  = DN_W'(it3_reg.vy) - corry4;
        fpx    = 64'(it3_reg.px);
        fpy    = 64'(it3_reg.py);
        fvx    = 64'(it3_reg.vx);
        fvy    = 64'(it3_reg.vy);
        unique case (it3_reg.mode)
            MODE_CIRCLE:
            begin
                if (it3_reg.hit)
                begin
                    fpx = 64'(posx3_reg);
                    fpy = 64'(posy3_reg);
                    fvx = 64'(velx4);
                    fvy = 64'(vely4);
                end
            end
            MODE_BOX:
            begin
                if (fpx < 0)
                begin
                    fpx = '0;
                    fvx = (-fvx) >>> 1;
                end
                else if (fpx >= SIZE64)
                begin
                    fpx = SIZE64 - TENTH64;
                    fvx = (-fvx) >>> 1;
                end
                if (fpy < 0)
                begin
                    fpy = '0;
                    fvy = (-fvy) >>> 1;
                end
                else if (fpy >= SIZE64)
                begin
                    fpy = SIZE64 - TENTH64;
                    fvy = (-fvy) >>> 1;
                end
            end
            default:
            begin
                fpx = 64'(it3_reg.px);
            end
        endcase
        res_next.new_pos_x = sat_pos(fpx);
        res_next.new_pos_y = sat_pos(fpy);
        res_next.new_vel_x = sat_vel(fvx);
        res_next.new_vel_y = sat_vel(fvy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg   <= in_item;
            nx1_reg   <= in_nx;
            ny1_reg   <= in_ny;
            pcx1_reg  <= in_nx * CENTER_S;
            pcy1_reg  <= in_ny * CENTER_S;
            dvx1_reg  <= in_item.vx * in_nx;
            dvy1_reg  <= in_item.vy * in_ny;
            it2_reg   <= it1_reg;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            dot2_reg  <= dot2_next;
            posx2_reg <= posx2_next;
            posy2_reg <= posy2_next;
            it3_reg   <= it2_reg;
            posx3_reg <= posx2_reg;
            posy3_reg <= posy2_reg;
            dnx3_reg  <= dot2_reg * nx2_reg;
            dny3_reg  <= dot2_reg * ny2_reg;
            it4_reg   <= it3_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = res_reg;

`ifndef NO_ASSERTIONS
    a_box_inside: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && it4_reg.mode == MODE_BOX |->
            64'(res_reg.new_pos_x) < SIZE64 && 64'(res_reg.new_pos_y) < SIZE64)
        else $error("box mode result outside the domain");

    a_circle_miss: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && it4_reg.mode == MODE_CIRCLE && !it4_reg.hit |->
            res_reg.new_vel_x == it4_reg.vx && res_reg.new_vel_y == it4_reg.vy)
        else $error("velocity changed without a wall hit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !en |=> v4_reg && $stable(res_reg))
        else $error("result beat changed while stalled");
`endif

endmodule

### tb/particle_advect_with_wall_bounce_tb.sv
// Testbench for particle_advect_with_wall_bounce: random and directed particle beats
// checked against an in-bench advection and wall model, under both boundary modes.
// Depends on pav_pkg and pav_stream_if.
`timescale 1ns / 100ps

module particle_advect_with_wall_bounce_tb;
    import pav_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
    localparam int DRAIN_CYCLES = 80;
    localparam int GRID = GRID_CELLS_DEF;
    localparam int FB = FRACTION_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pav_stream_if #(.payload_t(pav_in_t))  particle_ch ();
    pav_stream_if #(.payload_t(pav_out_t)) result_ch ();
    pav_stream_if #(.payload_t(pav_cfg_t)) cfg_ch ();

    particle_advect_with_wall_bounce DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle_ch.sink),
        .result   (result_ch.source),
        .cfg      (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    pav_in_t   particle_queue[$];
    pav_out_t  expected_results[$];
    logic [15:0] step_reg = TIME_STEP_RST;
    pav_mode_t mode_reg = MODE_CIRCLE;
    int mismatches = 0;
    int hold_kick = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int send_gap = 0;
    int take_stall = 0;
    logic send_burst = 1'b0;
    logic take_burst = 1'b0;

    initial
    begin
        particle_ch.valid = 1'b0;
        particle_ch.data = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic pav_out_t advect_particle(pav_in_t p, logic [15:0] step,
                                                 pav_mode_t mode);
        longint px, py, vx, vy, c, dx, dy, m, dxs, dys, cs, nx, ny, dot, root_len;
        longint size, tenth, ts;
        longint unsigned d2;
        int s;
        pav_out_t r;
        px = longint'(p.pos_x);
        py = longint'(p.pos_y);
        vx = longint'(p.vel_x);
        vy = longint'(p.vel_y);
        ts = longint'(step);
        px = px + rnd_shift(vx * ts, DT_W);
        py = py + rnd_shift(vy * ts, DT_W);
        if (mode == MODE_CIRCLE)
        begin
            c = longint'(GRID) <<< (FB - 1);
            dx = px - c;
            dy = py - c;
            m = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > m)
                m = (dy < 0) ? -dy : dy;
            if (c > m)
                m = c;
            s = 0;
            while ((m >>> s) >= (longint'(1) <<< 30))
                s++;
            dxs = trunc_shift(dx, s);
            dys = trunc_shift(dy, s);
            cs = c >>> s;
            d2 = longint'(dxs * dxs + dys * dys);
            if (d2 > longint'(cs * cs))
            begin
                root_len = int_sqrt(d2);
                if (root_len != 0)
                begin
                    nx = (dxs <<< NORM_BITS) / root_len;
                    ny = (dys <<< NORM_BITS) / root_len;
                    px = c + rnd_shift(nx * c, NORM_BITS);
                    py = c + rnd_shift(ny * c, NORM_BITS);
                    dot = rnd_shift(vx * nx + vy * ny, NORM_BITS);
                    vx = vx - rnd_shift(2 * dot * nx, NORM_BITS);
                    vy = vy - rnd_shift(2 * dot * ny, NORM_BITS);
                end
            end
        end
        else
        begin
            size = longint'(GRID) <<< FB;
            tenth = ((longint'(1) <<< FB) + 5) / 10;
            if (px < 0)
            begin
                px = 0;
                vx = (-vx) >>> 1;
            end
            else if (px >= size)
            begin
                px = size - tenth;
                vx = (-vx) >>> 1;
            end
            if (py < 0)
            begin
                py = 0;
                vy = (-vy) >>> 1;
            end
            else if (py >= size)
            begin
                py = size - tenth;
                vy = (-vy) >>> 1;
            end
        end
        r.new_pos_x = (px < 0) ? '0 : (px > 64'h7FFFFF) ? '1 : px[POS_W-1:0];
        r.new_pos_y = (py < 0) ? '0 : (py > 64'h7FFFFF) ? '1 : py[POS_W-1:0];
        r.new_vel_x = (vx < -64'sh800000) ? 24'h800000 :
                      (vx > 64'sh7FFFFF) ? 24'h7FFFFF : vx[VEL_W-1:0];
        r.new_vel_y = (vy < -64'sh800000) ? 24'h800000 :
                      (vy > 64'sh7FFFFF) ? 24'h7FFFFF : vy[VEL_W-1:0];
        return r;
    endfunction

    // driver: offer queued particles, record expectations on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_ch.valid <= 1'b0;
        end
        else
        begin
            if (particle_ch.valid && particle_ch.ready)
                expected_results.push_back(advect_particle(particle_ch.data, step_reg,
                                                           mode_reg));
            if (!particle_ch.valid || particle_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    particle_ch.valid <= 1'b0;
                end
                else if (particle_queue.size() > 0)
                begin
                    particle_ch.data <= particle_queue.pop_front();
                    particle_ch.valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        send_burst <= ~send_burst;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 3);
                end
                else
                    particle_ch.valid <= 1'b0;
            end
        end
    end

    // long hold-off of the result side
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= 300;
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        pav_out_t want;
        pav_out_t got;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.new_pos_x !== want.new_pos_x || got.new_pos_y !== want.new_pos_y ||
                        got.new_vel_x !== want.new_vel_x || got.new_vel_y !== want.new_vel_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected pos %h %h vel %h %h, got pos %h %h vel %h %h",
                                     want.new_pos_x, want.new_pos_y, want.new_vel_x,
                                     want.new_vel_y, got.new_pos_x, got.new_pos_y,
                                     got.new_vel_x, got.new_vel_y);
                    end
                end
            end
            if (hold_left > 0)
                result_ch.ready <= 1'b0;
            else if (take_stall > 0)
            begin
                take_stall <= take_stall - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (result_ch.valid && result_ch.ready && !take_burst &&
                    $urandom_range(0, 1) == 1)
                    result_ch.ready <= 1'b0;
                else
                    result_ch.ready <= 1'b1;
                if (result_ch.valid && result_ch.ready)
                begin
                    if ($urandom_range(0, 31) == 0)
                        take_burst <= ~take_burst;
                    if (!take_burst)
                        take_stall <= $urandom_range(0, 3);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.data <= '{index: idx, value: value};
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_TIME_STEP)
            step_reg = value;
        else if (idx == REG_BOUNDARY_MODE)
            mode_reg = pav_mode_t'(value[0]);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_particle(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy);
        particle_queue.push_back('{pos_x: x, pos_y: y, vel_x: vx, vel_y: vy});
    endtask

    task automatic add_random(int count);
        logic [POS_W-1:0] x, y;
        logic [VEL_W-1:0] vx, vy;
        for (int i = 0; i < count; i++)
        begin
            x = ($urandom_range(0, 7) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 4194304));
            y = ($urandom_range(0, 7) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 4194304));
            vx = ($urandom_range(0, 3) == 0) ? VEL_W'($urandom)
                 : VEL_W'(int'($urandom_range(0, 2097152)) - 1048576);
            vy = ($urandom_range(0, 3) == 0) ? VEL_W'($urandom)
                 : VEL_W'(int'($urandom_range(0, 2097152)) - 1048576);
            add_particle(x, y, vx, vy);
        end
    endtask

    task automatic drain;
        wait (particle_queue.size() == 0 && !particle_ch.valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: circle wall
        add_particle(23'd0, 23'd0, 24'h000000, 24'h000000);
        add_particle(23'd4194304, 23'd4194304, 24'h7FFFFF, 24'h7FFFFF);
        add_particle(23'h7FFFFF, 23'h7FFFFF, 24'h800000, 24'h800000);
        add_particle(23'd2097152, 23'd2097152, 24'h7FFFFF, 24'h800000);
        add_particle(23'd4194304, 23'd2097152, 24'h000000, 24'h000000);
        add_particle(23'd2097152, 23'd0, 24'h000000, 24'h000000);
        add_particle(23'h7FFFFF, 23'd0, 24'h123456, 24'hFEDCBA);
        add_particle(23'd0, 23'h7FFFFF, 24'h800000, 24'h7FFFFF);
        add_random(200);
        drain();

        write_reg(REG_TIME_STEP, 16'd0);
        write_reg(REG_BOUNDARY_MODE, 16'hFFFE);
        add_particle(23'd0, 23'd0, 24'h800000, 24'h7FFFFF);
        add_particle(23'd4194304, 23'h7FFFFF, 24'h7FFFFF, 24'h800000);
        add_particle(23'd4194303, 23'd1, 24'h000001, 24'hFFFFFF);
        add_random(200);
        drain();

        write_reg(REG_TIME_STEP, 16'hFFFF);
        add_particle(23'd0, 23'd0, 24'h800000, 24'h800000);
        add_particle(23'd4194304, 23'd4194304, 24'h7FFFFF, 24'h7FFFFF);
        add_particle(23'h7FFFFF, 23'd0, 24'h7FFFFF, 24'h800000);
        add_random(350);
        hold_kick = hold_kick + 1;
        drain();

        write_reg(REG_BOUNDARY_MODE, 16'd1);
        write_reg(REG_UNUSED, 16'h0000);
        add_particle(23'd0, 23'd0, 24'h800000, 24'h800000);
        add_particle(23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_random(350);
        hold_kick = hold_kick + 1;
        drain();

        write_reg(REG_TIME_STEP, 16'd1);
        add_random(200);
        drain();

        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_TIME_STEP, CFG_DATA_W'($urandom));
            write_reg(REG_BOUNDARY_MODE, CFG_DATA_W'($urandom));
            add_random(110);
            drain();
        end

        if (mismatches == 0)
            $display("particle_advect_with_wall_bounce_tb OK");
        else
            $display("particle_advect_with_wall_bounce_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("particle_advect_with_wall_bounce_tb NOT OK");
        $finish;
    end

endmodule

### files.f
hw/rtl/pav_pkg.sv
hw/rtl/pav_stream_if.sv
hw/rtl/pav_front.sv
hw/rtl/pav_sqrt.sv
hw/rtl/pav_div.sv
hw/rtl/pav_reflect.sv
hw/rtl/particle_advect_with_wall_bounce.sv
tb/particle_advect_with_wall_bounce_tb.sv
